### sv/aadu_pkg.sv
// ----------------------------------------------------------------------------
// aadu_pkg: shared types and constants
// Item formats, controller commands, state codes and register indexes of the
// channel averager with transient detection.
// ----------------------------------------------------------------------------
package aadu_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int CH_FIELD_W  = 3;
  localparam int SCALED_W    = 11;
  localparam int IRR_W       = 12;
  localparam int MODE_W      = 4;
  localparam int BAND_AVG_W  = 16;
  localparam int SUM_W       = 16;
  localparam int FRAC_BITS   = 6;
  localparam int WIN_FIELD_W = 6;
  localparam int THR_W       = 11;
  localparam int HOLD_W      = 16;
  localparam int ATT_W       = 2;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int SCALE_SHIFT = 10;

  localparam logic [MODE_W-1:0] MODE_BASE = 4'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTENUATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_D    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_EN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN    = 3'd7;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [SAMPLE_W-1:0]   sample;
  } sample_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0]  channel_out;
    logic [SAMPLE_W-1:0]    average;
    logic [SCALED_W-1:0]    scaled_value;
    logic signed [IRR_W-1:0] irregularity;
    logic                   audio_hit;
    logic [MODE_W-1:0]      mode_level;
    logic [BAND_AVG_W-1:0]  band_first_avg;
    logic [BAND_AVG_W-1:0]  band_second_avg;
    logic                   band_updated;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_CALC,
    ST_FEED,
    ST_DGO,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       ring_rd;
    logic       ring_cap;
    logic       ring_wr;
    logic [1:0] ring_idx;
    logic       calc;
    logic       feed;
    logic       div_start;
    logic       finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic new_ok;    // incoming channel is in range
    logic low;       // latched channel is 0..3
    logic div_done;
  } ctrl_stat_t;

  function automatic logic [SCALED_W-1:0] scale_of(input logic [ATT_W-1:0] att);
    logic [SCALED_W-1:0] s;
    unique case (att)
      2'd0:    s = 11'd2047;
      2'd1:    s = 11'd1551;
      default: s = 11'd1023;
    endcase
    return s;
  endfunction

endpackage

### sv/adc_average_audio_detect_unit.sv
// ----------------------------------------------------------------------------
// adc_average_audio_detect_unit: channel averager with transient detection
//
//   channel   dir  handshake                    beat
//   sample    in   sample_valid / sample_stall  sample_item (sample_t)
//   result    out  result_valid / result_stall  result_item (result_t)
//   config    in   wr_en                        wr_index, wr_data
//
// A sample on channels 0..3 passes through accept, three ring RAM reads and
// the ring write, calc, band feed, divide start, the bit-serial band divide
// and result load. Channels 4 and up skip the divide start and divide; an
// out-of-range channel goes from accept straight to result load. Reset is
// synchronous, clears the ring valid bits and the band store fill counts at
// once; no clearing pass. A stalled result holds in the output register
// while the next sample is worked on.
// ----------------------------------------------------------------------------
module adc_average_audio_detect_unit import aadu_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int BAND_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result_item,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  aadu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  aadu_dp #(.CHANNELS(CHANNELS), .BAND_DEPTH(BAND_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (sample_item),
    .out_item (result_item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

endmodule

### sv/aadu_ram.sv
// ----------------------------------------------------------------------------
// aadu_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aadu_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/aadu_div.sv
// ----------------------------------------------------------------------------
// aadu_div: restoring divider
// One quotient bit per cycle; done rises with the last quotient bit.
// ----------------------------------------------------------------------------
module aadu_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial    = {rem, quo[NUM_W-1]};
  assign ge       = trial >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(NUM_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

### sv/aadu_dp.sv
// ----------------------------------------------------------------------------
// aadu_dp: datapath
// Sample rings, detection, hold/mode state, band stores and band dividers,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module aadu_dp import aadu_pkg::*; #(
  parameter int CHANNELS   = 8,
  parameter int BAND_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output ctrl_stat_t           stat,
  input  sample_t              in_item,
  output result_t              out_item,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RING_DEPTH = CHANNELS * 4;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int PW         = $clog2(BAND_DEPTH);
  localparam int WIN_W      = $clog2(BAND_DEPTH + 1);
  localparam int NUM_W      = SUM_W + FRAC_BITS;

  // configuration
  logic [ATT_W-1:0]       att;
  logic [WIN_FIELD_W-1:0] win [4];
  logic                   audio_en;
  logic [THR_W-1:0]       thr;
  logic [HOLD_W-1:0]      hold_len;

  // item state
  logic [CH_FIELD_W-1:0]  ch;
  logic [SAMPLE_W-1:0]    smp;
  logic                   chv;
  logic [SAMPLE_W-1:0]    tap [3];
  logic                   rd_ok;
  logic [SAMPLE_W-1:0]    avg;
  logic [SCALED_W-1:0]    scaled;
  logic [IRR_W-1:0]       irr_r;
  logic                   hit;

  // block state
  logic [1:0]             slot;
  logic [RING_DEPTH-1:0]  ring_vld;
  logic [HOLD_W-1:0]      hold [2];
  logic [MODE_W-1:0]      mode;
  logic [SUM_W-1:0]       sums [4];
  logic [PW-1:0]          pos [4];
  logic [WIN_W-1:0]       fill [4];

  logic [CH_W-1:0]        ch_idx;
  logic [RING_AW-1:0]     ring_waddr;
  logic [RING_AW-1:0]     ring_raddr;
  logic [SAMPLE_W-1:0]    ring_rdata;
  logic [SAMPLE_W-1:0]    band_rdata [4];
  logic                   low;
  logic                   pair;
  logic                   last_ch;

  logic signed [IRR_W-1:0] irr;
  logic [IRR_W-1:0]       mag;
  logic [IRR_W-1:0]       sum4;
  logic                   hit_now;
  logic [HOLD_W-1:0]      hold_new [2];
  logic [MODE_W-1:0]      mode_hit;
  logic [20:0]            prod;

  logic [NUM_W-1:0]       quo0, quo1;
  logic                   done0, done1;

  function automatic logic [WIN_W-1:0] weff(input logic [WIN_FIELD_W-1:0] w);
    logic [WIN_W-1:0] x;
    x = WIN_W'(w);
    if (w == '0) begin
      x = WIN_W'(1);
    end else if (x > WIN_W'(BAND_DEPTH)) begin
      x = WIN_W'(BAND_DEPTH);
    end
    return x;
  endfunction

  function automatic logic [BAND_AVG_W-1:0] sat(input logic [NUM_W-1:0] q);
    return (q[NUM_W-1:BAND_AVG_W] != '0) ? '1 : q[BAND_AVG_W-1:0];
  endfunction

  assign ch_idx     = CH_W'(ch);
  assign ring_waddr = {ch_idx, slot};
  assign ring_raddr = {ch_idx, slot - cmd.ring_idx - 2'd1};
  assign low        = (ch[CH_FIELD_W-1:2] == '0);
  assign pair       = ch[0];
  assign last_ch    = (32'(ch) == CHANNELS - 1);

  assign stat.new_ok   = (32'(in_item.channel) < CHANNELS);
  assign stat.low      = low;
  assign stat.div_done = done0 & done1;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      att      <= '0;
      win[0]   <= 6'd15;
      win[1]   <= 6'd47;
      win[2]   <= 6'd15;
      win[3]   <= 6'd47;
      audio_en <= 1'b0;
      thr      <= 11'd160;
      hold_len <= 16'd1000;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ATTENUATION: att      <= wr_data[ATT_W-1:0];
        REG_WINDOW_A:    win[0]   <= wr_data[WIN_FIELD_W-1:0];
        REG_WINDOW_B:    win[1]   <= wr_data[WIN_FIELD_W-1:0];
        REG_WINDOW_C:    win[2]   <= wr_data[WIN_FIELD_W-1:0];
        REG_WINDOW_D:    win[3]   <= wr_data[WIN_FIELD_W-1:0];
        REG_AUDIO_EN:    audio_en <= wr_data[0];
        REG_THRESHOLD:   thr      <= wr_data[THR_W-1:0];
        REG_HOLD_LEN:    hold_len <= wr_data[HOLD_W-1:0];
        default:         ;
      endcase
    end
  end

  aadu_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.ring_wr),
    .waddr (ring_waddr),
    .wdata (smp),
    .re    (cmd.ring_rd),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // detection math on the gathered ring
  always_comb begin
    irr  = $signed({2'b00, smp}) - $signed({2'b00, tap[0]})
         + $signed({2'b00, tap[1]}) - $signed({2'b00, tap[2]});
    mag  = irr[IRR_W-1] ? IRR_W'(-irr) : IRR_W'(irr);
    sum4 = {2'b00, smp} + {2'b00, tap[0]} + {2'b00, tap[1]} + {2'b00, tap[2]};
    hit_now = audio_en && low && (mag > {1'b0, thr});
    hold_new[0] = (pair == 1'b0) ? hold_len : hold[0];
    hold_new[1] = (pair == 1'b1) ? hold_len : hold[1];
    mode_hit = MODE_BASE + {2'b00, (hold_new[0] != '0), 1'b0}
                         + {2'b00, (hold_new[1] != '0), 1'b0};
    prod = avg * scale_of(att);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch  <= in_item.channel;
      smp <= in_item.sample;
      chv <= stat.new_ok;
    end
    if (cmd.ring_rd) begin
      rd_ok <= ring_vld[ring_raddr];
    end
    if (cmd.ring_cap) begin
      tap[cmd.ring_idx - 2'd1] <= rd_ok ? ring_rdata : '0;
    end
    if (cmd.calc) begin
      avg   <= sum4[IRR_W-1:2];
      irr_r <= low ? IRR_W'(irr) : '0;
      hit   <= hit_now;
    end
    if (cmd.feed) begin
      scaled <= prod[20:SCALE_SHIFT];
    end
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      ring_vld <= '0;
      hold[0]  <= '0;
      hold[1]  <= '0;
      mode     <= MODE_BASE;
    end else begin
      if (cmd.accept && stat.new_ok && in_item.channel == '0) begin
        mode <= MODE_BASE;
      end
      if (cmd.ring_wr) begin
        ring_vld[ring_waddr] <= 1'b1;
      end
      if (cmd.calc && hit_now) begin
        hold[0] <= hold_new[0];
        hold[1] <= hold_new[1];
        mode    <= mode_hit;
      end
      // scan end
      if (cmd.finish && chv && last_ch) begin
        if (hold[0] != '0) hold[0] <= hold[0] - 1'b1;
        if (hold[1] != '0) hold[1] <= hold[1] - 1'b1;
        slot <= slot + 2'd1;
      end
    end
  end

  // band stores; positions only step up from zero or wrap to zero, so the
  // written entries are always those below the fill count
  for (genvar b = 0; b < 4; b++) begin : g_band
    logic                 bwe;
    logic [SAMPLE_W-1:0]  old;
    logic [WIN_W-1:0]     pinc;

    assign bwe  = cmd.feed && hit && (int'(pair) == b / 2);
    assign old  = (WIN_W'(pos[b]) < fill[b]) ? band_rdata[b] : '0;
    assign pinc = WIN_W'(pos[b]) + WIN_W'(1);

    aadu_ram #(.WIDTH(SAMPLE_W), .DEPTH(BAND_DEPTH)) u_store (
      .clk   (clk),
      .we    (bwe),
      .waddr (pos[b]),
      .wdata (smp),
      .re    (cmd.calc),
      .raddr (pos[b]),
      .rdata (band_rdata[b])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sums[b] <= '0;
        pos[b]  <= '0;
        fill[b] <= '0;
      end else if (bwe) begin
        sums[b] <= sums[b] - SUM_W'(old) + SUM_W'(smp);
        if (WIN_W'(pos[b]) == fill[b]) begin
          fill[b] <= pinc;
        end
        pos[b]  <= (pinc >= weff(win[b])) ? '0 : PW'(pinc);
      end
    end
  end

  aadu_div #(.NUM_W(NUM_W), .DEN_W(WIN_W)) u_div0 (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({sums[{pair, 1'b0}], FRAC_BITS'(0)}),
    .divisor  (weff(win[{pair, 1'b0}])),
    .quotient (quo0),
    .done     (done0)
  );

  aadu_div #(.NUM_W(NUM_W), .DEN_W(WIN_W)) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({sums[{pair, 1'b1}], FRAC_BITS'(0)}),
    .divisor  (weff(win[{pair, 1'b1}])),
    .quotient (quo1),
    .done     (done1)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.channel_out     <= ch;
      out_item.average         <= chv ? avg : '0;
      out_item.scaled_value    <= chv ? scaled : '0;
      out_item.irregularity    <= chv ? irr_r : '0;
      out_item.audio_hit       <= chv && hit;
      out_item.mode_level      <= mode;
      out_item.band_first_avg  <= (chv && low) ? sat(quo0) : '0;
      out_item.band_second_avg <= (chv && low) ? sat(quo1) : '0;
      out_item.band_updated    <= chv && hit;
    end
  end

endmodule

### sv/aadu_ctrl.sv
// ----------------------------------------------------------------------------
// aadu_ctrl: sequencing controller
// Steps an in-range sample through ring gather, detection, band update and, for channels 0..3, divide,
// and owns the input stall and the result valid flag.
// ----------------------------------------------------------------------------
module aadu_ctrl import aadu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  output logic       result_valid,
  input  logic       result_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t     state, state_next;
  logic [1:0] rcnt, rcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rcnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      rcnt  <= rcnt_next;
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sample_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    rcnt_next  = rcnt;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.accept = 1'b1;
          rcnt_next  = '0;
          state_next = stat.new_ok ? ST_RING : ST_DONE;
        end
      end
      ST_RING: begin
        // read three older taps, then write the new sample
        cmd.ring_idx = rcnt;
        cmd.ring_rd  = (rcnt != 2'd3);
        cmd.ring_cap = (rcnt != 2'd0);
        cmd.ring_wr  = (rcnt == 2'd3);
        rcnt_next    = rcnt + 2'd1;
        if (rcnt == 2'd3) state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_FEED;
      end
      ST_FEED: begin
        cmd.feed   = 1'b1;
        state_next = stat.low ? ST_DGO : ST_DONE;
      end
      ST_DGO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### verif/tb_adc_average_audio_detect_unit.sv
// ----------------------------------------------------------------------------
// tb_adc_average_audio_detect_unit: self-checking bench for the channel averager
// Drives sample scans with random gaps, stalls the result side at random and
// checks every result beat against an in-bench predictor of rings, transient
// detection, hold counters and band moving averages.
// ----------------------------------------------------------------------------
module tb_adc_average_audio_detect_unit;
  import aadu_pkg::*;

  localparam int NCH   = 8;
  localparam int BDEP  = 64;
  localparam int LIMIT = 2000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample_item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result_item;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0]     wr_data = '0;

  adc_average_audio_detect_unit #(.CHANNELS(NCH), .BAND_DEPTH(BDEP)) u_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [1:0]  att_q;
  logic [5:0]  win_q [4];
  logic        aen_q;
  logic [10:0] thr_q;
  logic [15:0] hold_len_q;
  logic [9:0]  ring [NCH][4];
  logic [1:0]  slot;
  logic [9:0]  band_cells [4][BDEP];
  logic [15:0] band_sum [4];
  int          band_pos [4];
  logic [15:0] hold_cnt [2];
  logic [3:0]  mode_reg;

  result_t expected_results[$];
  int      fail_cnt = 0;
  int      cycle = 0;
  int      stall_mode = 1;

  function automatic int eff_window(int b);
    int w;
    w = win_q[b];
    if (w < 1) w = 1;
    if (w > BDEP) w = BDEP;
    return w;
  endfunction

  function automatic logic [15:0] band_avg(int b);
    longint q;
    q = ((longint'(band_sum[b]) << 6) & 32'hFFFF_FFFF) / eff_window(b);
    return q > 65535 ? 16'hFFFF : q[15:0];
  endfunction

  task automatic band_push(int b, logic [9:0] s);
    int p;
    p = band_pos[b];
    if (p >= BDEP) p = 0;
    band_sum[b] = band_sum[b] - band_cells[b][p] + s;
    band_cells[b][p] = s;
    p++;
    if (p >= eff_window(b)) p = 0;
    band_pos[b] = p;
  endtask

  task automatic predict_sample(sample_t it);
    result_t r;
    int ch, irr, mag, pair, sum;
    logic [1:0] sl;
    ch = int'(it.channel);
    r = '0;
    r.channel_out = it.channel;
    if (ch < NCH) begin
      sl = slot;
      if (ch == 0) mode_reg = MODE_BASE;
      ring[ch][sl] = it.sample;
      if (ch < 4) begin
        irr = int'(ring[ch][sl]) - int'(ring[ch][sl+2'd3]) + int'(ring[ch][sl+2'd2])
            - int'(ring[ch][sl+2'd1]);
        mag = irr < 0 ? -irr : irr;
        pair = ch & 1;
        r.irregularity = irr[11:0];
        if (aen_q && mag > int'(thr_q)) begin
          r.audio_hit = 1'b1;
          r.band_updated = 1'b1;
          hold_cnt[pair] = hold_len_q;
          mode_reg = 4'd5 + 4'd2 * ((hold_cnt[0] != 0) + (hold_cnt[1] != 0));
          band_push(pair * 2, it.sample);
          band_push(pair * 2 + 1, it.sample);
        end
        r.band_first_avg = band_avg(pair * 2);
        r.band_second_avg = band_avg(pair * 2 + 1);
      end
      sum = ring[ch][0] + ring[ch][1] + ring[ch][2] + ring[ch][3];
      r.average = 10'(sum >> 2);
      sum = (sum >> 2) * (att_q == 2'd0 ? 2047 : att_q == 2'd1 ? 1551 : 1023);
      r.scaled_value = 11'(sum >> 10);
      if (ch == NCH - 1) begin
        if (hold_cnt[0] != 0) hold_cnt[0]--;
        if (hold_cnt[1] != 0) hold_cnt[1]--;
        slot = slot + 2'd1;
      end
    end
    r.mode_level = mode_reg;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_cnt++;
  endtask

  // valid stays up after an accepted beat until the next beat or a gap
  task automatic send_sample(logic [2:0] ch, logic [9:0] s);
    sample_t it;
    int gap;
    gap = int'($urandom_range(0, 16)) * int'($urandom_range(0, 3) != 0);
    it.channel = ch;
    it.sample = s;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item <= it;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predict_sample(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    sample_valid <= 1'b0;
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_ATTENUATION: att_q = val[1:0];
      REG_WINDOW_A:    win_q[0] = val[5:0];
      REG_WINDOW_B:    win_q[1] = val[5:0];
      REG_WINDOW_C:    win_q[2] = val[5:0];
      REG_WINDOW_D:    win_q[3] = val[5:0];
      REG_AUDIO_EN:    aen_q = val[0];
      REG_THRESHOLD:   thr_q = val[10:0];
      default:         hold_len_q = val;
    endcase
    @(posedge clk);
  endtask

  task automatic drain;
    sample_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_scan(int kind);
    for (int c = 0; c < NCH; c++) begin
      case (kind)
        0: send_sample(3'(c), 10'($urandom_range(0, 1023)));
        1: send_sample(3'(c), (slot[0] ^ c[0]) ? 10'h3FF : 10'h000);
        default: send_sample(3'(c), ($urandom_range(0, 1) != 0) ? 10'h3FF
                                    : 10'($urandom_range(0, 1023)));
      endcase
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t w;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, channel", result_item.channel_out, -1);
      end else begin
        w = expected_results.pop_front();
        if (result_item.channel_out !== w.channel_out)
          report_mismatch("channel_out", result_item.channel_out, w.channel_out);
        if (result_item.average !== w.average)
          report_mismatch("average", result_item.average, w.average);
        if (result_item.scaled_value !== w.scaled_value)
          report_mismatch("scaled_value", result_item.scaled_value, w.scaled_value);
        if (result_item.irregularity !== w.irregularity)
          report_mismatch("irregularity", result_item.irregularity, w.irregularity);
        if (result_item.audio_hit !== w.audio_hit)
          report_mismatch("audio_hit", result_item.audio_hit, w.audio_hit);
        if (result_item.mode_level !== w.mode_level)
          report_mismatch("mode_level", result_item.mode_level, w.mode_level);
        if (result_item.band_first_avg !== w.band_first_avg)
          report_mismatch("band_first_avg", result_item.band_first_avg, w.band_first_avg);
        if (result_item.band_second_avg !== w.band_second_avg)
          report_mismatch("band_second_avg", result_item.band_second_avg,
                          w.band_second_avg);
        if (result_item.band_updated !== w.band_updated)
          report_mismatch("band_updated", result_item.band_updated, w.band_updated);
      end
    end
  end

  // stall draw: a run of stalled cycles then one open cycle
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_mode == 0) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      stall_left <= int'($urandom_range(0, 16));
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("tb_adc_average_audio_detect_unit NOT OK");
      $finish;
    end
  end

  task automatic test_directed;
    write_reg(REG_AUDIO_EN, 16'd1);
    write_reg(REG_THRESHOLD, 16'd0);
    // out-of-range-free checks: two scans of alternating full swing
    send_scan(1);
    send_scan(1);
    drain();
    write_reg(REG_WINDOW_A, 16'd0);
    write_reg(REG_WINDOW_B, 16'd63);
    write_reg(REG_WINDOW_C, 16'd1);
    write_reg(REG_WINDOW_D, 16'd2);
    write_reg(REG_ATTENUATION, 16'd3);
    write_reg(REG_HOLD_LEN, 16'd0);
    send_scan(1);
    drain();
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ATTENUATION, 16'($urandom_range(0, 3)));
      write_reg(REG_WINDOW_A, ph == 0 ? 16'd63 : 16'($urandom_range(0, 63)));
      write_reg(REG_WINDOW_B, ph == 1 ? 16'd1 : 16'($urandom_range(0, 63)));
      write_reg(REG_WINDOW_C, 16'($urandom_range(0, 63)));
      write_reg(REG_WINDOW_D, 16'($urandom_range(0, 63)));
      write_reg(REG_AUDIO_EN, 16'(ph != 3));
      write_reg(REG_THRESHOLD, ph == 2 ? 16'd2047 : 16'($urandom_range(0, 900)));
      write_reg(REG_HOLD_LEN, ph == 4 ? 16'hFFFF : 16'($urandom_range(0, 6)));
      stall_mode = int'(ph != 5);
      for (int sc = 0; sc < 15; sc++) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
        else
          send_scan(int'($urandom_range(0, 2)));
      end
      drain();
    end
  endtask

  initial begin
    att_q = 2'd0;
    win_q = '{6'd15, 6'd47, 6'd15, 6'd47};
    aen_q = 1'b0;
    thr_q = 11'd160;
    hold_len_q = 16'd1000;
    ring = '{default: '{default: '0}};
    slot = '0;
    band_cells = '{default: '{default: '0}};
    band_sum = '{default: '0};
    band_pos = '{default: 0};
    hold_cnt = '{default: '0};
    mode_reg = MODE_BASE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    if (fail_cnt == 0 && expected_results.size() == 0)
      $display("tb_adc_average_audio_detect_unit OK");
    else
      $display("tb_adc_average_audio_detect_unit NOT OK");
    $finish;
  end
endmodule
